// ----- hw/rtl/dhlt_pkg.sv -----
// ============================================================================
// dhlt_pkg: shared constants for the link transform block
// Fixed-point constants, CORDIC arctangent table and queue entry type.
// ============================================================================
package dhlt_pkg;

  localparam logic signed [33:0] CORDIC_INV_GAIN = 34'sh026DD3B6A;
  localparam logic signed [33:0] PHASE_QUARTER   = 34'sh040000000;
  localparam logic signed [33:0] PHASE_HALF      = 34'sh080000000;

  // Arctangent of 2^-i in phase units (full turn = 2^32).
  function automatic logic [29:0] atan_phase(input logic [4:0] i);
    logic [29:0] r;
    case (i)
      5'd0:  r = 30'h20000000;
      5'd1:  r = 30'h12E4051E;
      5'd2:  r = 30'h09FB385B;
      5'd3:  r = 30'h051111D4;
      5'd4:  r = 30'h028B0D43;
      5'd5:  r = 30'h0145D7E1;
      5'd6:  r = 30'h00A2F61E;
      5'd7:  r = 30'h00517C55;
      5'd8:  r = 30'h0028BE53;
      5'd9:  r = 30'h00145F2F;
      5'd10: r = 30'h000A2F98;
      5'd11: r = 30'h000517CC;
      5'd12: r = 30'h00028BE6;
      5'd13: r = 30'h000145F3;
      5'd14: r = 30'h0000A2F9;
      5'd15: r = 30'h0000517C;
      5'd16: r = 30'h000028BE;
      5'd17: r = 30'h0000145F;
      5'd18: r = 30'h00000A2F;
      5'd19: r = 30'h00000517;
      5'd20: r = 30'h0000028B;
      5'd21: r = 30'h00000145;
      5'd22: r = 30'h000000A2;
      5'd23: r = 30'h00000051;
      5'd24: r = 30'h00000028;
      5'd25: r = 30'h00000014;
      5'd26: r = 30'h0000000A;
      5'd27: r = 30'h00000005;
      5'd28: r = 30'h00000002;
      5'd29: r = 30'h00000001;
      default: r = 30'h0;
    endcase
    return r;
  endfunction

  // One queued link item after angle conversion and quadrant folding.
  typedef struct packed {
    logic signed [33:0] phase_al;
    logic               flip_al;
    logic signed [33:0] phase_th;
    logic               flip_th;
    logic signed [31:0] len_a;
    logic signed [31:0] len_d;
  } link_item_t;

endpackage

// ----- hw/rtl/dhlt_front.sv -----
// ============================================================================
// dhlt_front: item intake
// Converts both angles to phase, folds quadrants and pushes into a queue.
// ============================================================================
module dhlt_front
  import dhlt_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic signed [15:0] twist_angle,
  input  logic signed [31:0] link_length,
  input  logic signed [31:0] link_offset,
  input  logic signed [15:0] joint_angle,
  output logic               busy,
  output logic               q_valid,
  output link_item_t         q_item,
  input  logic               q_pop
);

  // phase = trunc(angle * 2^32 / 46080) = trunc(angle * 2^22 / 45).
  // Magnitude reciprocal: floor(m * 2^22 / 45) for m <= 2^15 via a multiply.
  localparam logic [37:0] RECIP = 38'd195468733827; // ceil(2^43 / 45)

  function automatic logic signed [33:0] to_phase(input logic signed [15:0] ang);
    logic [15:0] mag;
    logic [53:0] prod;
    logic [33:0] q;
    mag  = ang[15] ? 16'(-ang) : ang;
    prod = 54'(mag) * 54'(RECIP);
    q    = {1'b0, prod[53:21]};
    return ang[15] ? -$signed(q) : $signed(q);
  endfunction

  // Quotient exactness: the reciprocal error adds less than 1/400 to m*2^22/45,
  // whose fraction is at most 44/45, so the floor is never disturbed.

  link_item_t q_mem [2];
  logic       wr_ptr, rd_ptr;
  logic [1:0] count;

  // Phase computed over one registered stage to keep multiplier isolated.
  logic               s1_valid;
  logic signed [33:0] s1_pa, s1_pt;
  logic signed [31:0] s1_a, s1_d;
  link_item_t         folded;

  always_comb begin
    folded.len_a = s1_a;
    folded.len_d = s1_d;
    folded.flip_al = (s1_pa > PHASE_QUARTER) || (s1_pa < -PHASE_QUARTER);
    folded.phase_al = (s1_pa > PHASE_QUARTER) ? s1_pa - PHASE_HALF :
                      (s1_pa < -PHASE_QUARTER) ? s1_pa + PHASE_HALF : s1_pa;
    folded.flip_th = (s1_pt > PHASE_QUARTER) || (s1_pt < -PHASE_QUARTER);
    folded.phase_th = (s1_pt > PHASE_QUARTER) ? s1_pt - PHASE_HALF :
                      (s1_pt < -PHASE_QUARTER) ? s1_pt + PHASE_HALF : s1_pt;
  end

  logic accept;
  assign accept = start && !busy;
  // Keep one slot free for an item in the phase stage.
  assign busy = (count + {1'b0, s1_valid}) >= 2'd2;
  assign q_valid = count != 2'd0;
  assign q_item = q_mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_pa <= to_phase(twist_angle);
      s1_pt <= to_phase(joint_angle);
      s1_a  <= link_length;
      s1_d  <= link_offset;
    end
    if (s1_valid) begin
      q_mem[wr_ptr] <= folded;
    end
    if (rst) begin
      s1_valid <= 1'b0;
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count <= 2'd0;
    end else begin
      s1_valid <= accept;
      if (s1_valid) wr_ptr <= ~wr_ptr;
      if (q_pop) rd_ptr <= ~rd_ptr;
      count <= count + {1'b0, s1_valid} - {1'b0, q_pop};
    end
  end

endmodule

// ----- hw/rtl/dhlt_cordic.sv -----
// ============================================================================
// dhlt_cordic: pipelined rotation CORDIC
// One stage per register; yields sine and cosine rounded to Q16.16.
// ============================================================================
module dhlt_cordic
  import dhlt_pkg::*;
#(
  parameter int STAGES = 24
) (
  input  logic               clk,
  input  logic signed [33:0] phase,
  input  logic               flip,
  output logic signed [33:0] cos_q,
  output logic signed [33:0] sin_q
);

  localparam int N = (STAGES > 32) ? 32 : STAGES;

  logic signed [33:0] xs [N+1];
  logic signed [33:0] ys [N+1];
  logic signed [33:0] zs [N+1];
  logic               fs [N+1];

  assign xs[0] = CORDIC_INV_GAIN;
  assign ys[0] = '0;
  assign zs[0] = phase;
  assign fs[0] = flip;

  for (genvar i = 0; i < N; i++) begin : g_stage
    logic signed [33:0] dx, dy, at;
    assign dx = ys[i] >>> i;
    assign dy = xs[i] >>> i;
    assign at = $signed({4'd0, atan_phase(5'(i))});
    always_ff @(posedge clk) begin
      if (zs[i] >= 0) begin
        xs[i+1] <= xs[i] - dx;
        ys[i+1] <= ys[i] + dy;
        zs[i+1] <= zs[i] - at;
      end else begin
        xs[i+1] <= xs[i] + dx;
        ys[i+1] <= ys[i] - dy;
        zs[i+1] <= zs[i] + at;
      end
      fs[i+1] <= fs[i];
    end
  end

  logic signed [33:0] cr, sr;
  assign cr = (xs[N] + 34'sd8192) >>> 14;
  assign sr = (ys[N] + 34'sd8192) >>> 14;
  assign cos_q = fs[N] ? -cr : cr;
  assign sin_q = fs[N] ? -sr : sr;

endmodule

// ----- hw/rtl/dhlt_back.sv -----
// ============================================================================
// dhlt_back: matrix row sequencer
// Pops queued items, runs both CORDICs, and emits four rows per item.
// ============================================================================
module dhlt_back
  import dhlt_pkg::*;
#(
  parameter int VALUE_WIDTH   = 32,
  parameter int CORDIC_STAGES = 24
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          q_valid,
  input  link_item_t                    q_item,
  output logic                          q_pop,
  output logic                          done,
  output logic [1:0]                    row_index,
  output logic signed [VALUE_WIDTH-1:0] col_zero,
  output logic signed [VALUE_WIDTH-1:0] col_one,
  output logic signed [VALUE_WIDTH-1:0] col_two,
  output logic signed [VALUE_WIDTH-1:0] col_three,
  output logic                          last_row
);

  localparam int N   = (CORDIC_STAGES > 32) ? 32 : CORDIC_STAGES;
  localparam int LAT = N; // one slot per CORDIC stage; capture follows the last

  // Gap counter paces pops to one item per four rows; the CORDIC pipeline absorbs the rest.
  logic [1:0] gap;
  assign q_pop = q_valid && (gap == 2'd0);

  logic [LAT-1:0]         vpipe;
  logic signed [31:0]     apipe [LAT];
  logic signed [31:0]     dpipe [LAT];

  logic signed [33:0] ca, sa, ct, st;
  dhlt_cordic #(.STAGES(N)) u_al (
    .clk(clk), .phase(q_item.phase_al),
    .flip(q_item.flip_al), .cos_q(ca), .sin_q(sa));
  dhlt_cordic #(.STAGES(N)) u_th (
    .clk(clk), .phase(q_item.phase_th),
    .flip(q_item.flip_th), .cos_q(ct), .sin_q(st));

  // Captured trig and lengths for the row sequencer.
  logic signed [33:0] r_ca, r_sa, r_ct, r_st;
  logic signed [31:0] r_a, r_d;
  logic [1:0]         row;
  logic               active;

  // Product stage: one 34x34 multiply per product, three run in parallel.
  function automatic logic signed [VALUE_WIDTH-1:0] sat(input logic signed [67:0] v);
    logic signed [67:0] hi, lo;
    hi = (68'sd1 <<< (VALUE_WIDTH-1)) - 68'sd1;
    lo = -hi - 68'sd1;
    if (v > hi) return hi[VALUE_WIDTH-1:0];
    if (v < lo) return lo[VALUE_WIDTH-1:0];
    return v[VALUE_WIDTH-1:0];
  endfunction

  logic signed [67:0] p0, p1, p2;
  logic signed [33:0] m0a, m0b, m1a, m1b, m2a, m2b;
  logic               n0, n1;
  always_comb begin
    m0a = r_st; m0b = r_ca; m1a = r_st; m1b = r_sa; m2a = {{2{r_a[31]}}, r_a}; m2b = r_ct;
    n0 = 1'b1; n1 = 1'b0;
    if (row == 2'd1) begin
      m0a = r_ct; m0b = r_ca; m1a = r_ct; m1b = r_sa; m2b = r_st;
      n0 = 1'b0; n1 = 1'b1;
    end
    p0 = m0a * m0b;
    p1 = m1a * m1b;
    p2 = m2a * m2b;
    if (n0) p0 = -p0;
    if (n1) p1 = -p1;
  end

  always_ff @(posedge clk) begin
    for (int k = 1; k < LAT; k++) begin
      apipe[k] <= apipe[k-1];
      dpipe[k] <= dpipe[k-1];
    end
    apipe[0] <= q_item.len_a;
    dpipe[0] <= q_item.len_d;
    if (vpipe[LAT-1]) begin
      r_ca <= ca; r_sa <= sa; r_ct <= ct; r_st <= st;
      r_a <= apipe[LAT-1]; r_d <= dpipe[LAT-1];
    end
    row_index <= row;
    last_row  <= row == 2'd3;
    case (row)
      2'd0, 2'd1: begin
        col_zero  <= sat(68'(row == 2'd0 ? r_ct : r_st));
        col_one   <= sat((p0 + 68'sd32768) >>> 16);
        col_two   <= sat((p1 + 68'sd32768) >>> 16);
        col_three <= sat((p2 + 68'sd32768) >>> 16);
      end
      2'd2: begin
        col_zero  <= '0;
        col_one   <= sat(68'(r_sa));
        col_two   <= sat(68'(r_ca));
        col_three <= sat(68'(r_d));
      end
      default: begin
        col_zero  <= '0;
        col_one   <= '0;
        col_two   <= '0;
        col_three <= sat(68'sd65536);
      end
    endcase
    if (rst) begin
      gap <= 2'd0;
      vpipe <= '0;
      row <= 2'd0;
      active <= 1'b0;
      done <= 1'b0;
    end else begin
      gap <= (q_pop || gap != 2'd0) ? gap + 2'd1 : 2'd0;
      vpipe <= {vpipe[LAT-2:0], q_pop};
      done <= active;
      if (vpipe[LAT-1]) begin
        active <= 1'b1;
        row <= 2'd0;
      end else if (active) begin
        row <= row + 2'd1;
        if (row == 2'd3) active <= 1'b0;
      end
    end
  end

endmodule

// ----- hw/rtl/dh_link_transform_core.sv -----
// ============================================================================
// dh_link_transform_core: Denavit-Hartenberg link transform
// Forms Tz(d)*Rz(theta)*Tx(a)*Rx(alpha) and emits it as four row items.
// ============================================================================
// A link item is taken when start is high and busy is low. Each item yields
// four row items on consecutive cycles, row 0 first, each marked by done for
// one cycle with last_row set on row 3; the receiver cannot stall them, so
// they must be taken as they come. When saturated, the block accepts items
// only as fast as the single row sequencer streams four rows per item, yet
// it takes a new item while earlier ones are still in flight. With an empty
// queue, the accepting edge loads the angle conversion register, a queue
// write follows, the pop edge and the edges after it fill the CORDIC stages,
// then one capture and one output register bring row 0 to the ports. Both
// sines and cosines come from two pipelined CORDICs that run side by side;
// all elements saturate to VALUE_WIDTH bits.
module dh_link_transform_core
  import dhlt_pkg::*;
#(
  parameter int VALUE_WIDTH   = 32,
  parameter int CORDIC_STAGES = 24
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  output logic                          busy,
  input  logic signed [15:0]            twist_angle,
  input  logic signed [31:0]            link_length,
  input  logic signed [31:0]            link_offset,
  input  logic signed [15:0]            joint_angle,
  output logic                          done,
  output logic [1:0]                    row_index,
  output logic signed [VALUE_WIDTH-1:0] col_zero,
  output logic signed [VALUE_WIDTH-1:0] col_one,
  output logic signed [VALUE_WIDTH-1:0] col_two,
  output logic signed [VALUE_WIDTH-1:0] col_three,
  output logic                          last_row
);

  // The front stage converts and queues items; the back stage drains them.
  logic       q_valid, q_pop;
  link_item_t q_item;

  dhlt_front u_front (
    .clk(clk), .rst(rst), .start(start),
    .twist_angle(twist_angle), .link_length(link_length),
    .link_offset(link_offset), .joint_angle(joint_angle),
    .busy(busy), .q_valid(q_valid), .q_item(q_item), .q_pop(q_pop));

  dhlt_back #(.VALUE_WIDTH(VALUE_WIDTH), .CORDIC_STAGES(CORDIC_STAGES)) u_back (
    .clk(clk), .rst(rst), .q_valid(q_valid), .q_item(q_item), .q_pop(q_pop),
    .done(done), .row_index(row_index), .col_zero(col_zero), .col_one(col_one),
    .col_two(col_two), .col_three(col_three), .last_row(last_row));

endmodule

// ----- tb/sv/dh_link_transform_core_tb.sv -----
// ============================================================================
// dh_link_transform_core_tb: self-checking bench for the link transform core
// Sends link items, predicts all four matrix rows and checks each row item.
// ============================================================================
`timescale 1ns / 100ps

module dh_link_transform_core_tb;
  import dhlt_pkg::*;

  localparam int VW = 32;
  localparam int STAGES = 24;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic busy;
  logic signed [15:0] twist_angle = '0;
  logic signed [31:0] link_length = '0;
  logic signed [31:0] link_offset = '0;
  logic signed [15:0] joint_angle = '0;
  logic done;
  logic [1:0] row_index;
  logic signed [VW-1:0] col_zero, col_one, col_two, col_three;
  logic last_row;

  // One expected row of the link matrix.
  typedef struct {
    logic [1:0] row;
    logic signed [VW-1:0] c0, c1, c2, c3;
    logic last;
  } matrix_row_t;

  matrix_row_t rows_due[$];
  int errors = 0;
  bit quiet_stretch = 1'b0;

  dh_link_transform_core #(.VALUE_WIDTH(VW), .CORDIC_STAGES(STAGES)) dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .twist_angle(twist_angle), .link_length(link_length),
    .link_offset(link_offset), .joint_angle(joint_angle),
    .done(done), .row_index(row_index), .col_zero(col_zero), .col_one(col_one),
    .col_two(col_two), .col_three(col_three), .last_row(last_row)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // The arctangent table of the block, in phase units of a full turn of 2^32.
  function automatic longint arctan_step(int i);
    longint t[30] = '{
      64'h20000000, 64'h12E4051E, 64'h09FB385B, 64'h051111D4, 64'h028B0D43,
      64'h0145D7E1, 64'h00A2F61E, 64'h00517C55, 64'h0028BE53, 64'h00145F2F,
      64'h000A2F98, 64'h000517CC, 64'h00028BE6, 64'h000145F3, 64'h0000A2F9,
      64'h0000517C, 64'h000028BE, 64'h0000145F, 64'h00000A2F, 64'h00000517,
      64'h0000028B, 64'h00000145, 64'h000000A2, 64'h00000051, 64'h00000028,
      64'h00000014, 64'h0000000A, 64'h00000005, 64'h00000002, 64'h00000001};
    if (i < 30) return t[i];
    return 64'sd0;
  endfunction

  // SystemVerilog >>> on a signed longint is already a floor shift.
  function automatic longint round_q(longint v, int s);
    return (v + (longint'(1) << (s - 1))) >>> s;
  endfunction

  function automatic logic signed [VW-1:0] clamp(longint v);
    longint hi, lo;
    hi = (longint'(1) << (VW - 1)) - 1;
    lo = -hi - 1;
    if (v > hi) return hi[VW-1:0];
    if (v < lo) return lo[VW-1:0];
    return v[VW-1:0];
  endfunction

  // Sine and cosine of an angle in 1/128 degree, Q16.16, by the folded CORDIC.
  task automatic trig_of(input logic signed [15:0] ang, output longint c,
                         output longint s);
    longint ph, x, y, z, dx, dy;
    bit flip;
    int n;
    ph = longint'(ang) * 64'sd4294967296 / 46080;
    flip = 1'b0;
    if (ph > (longint'(1) << 30)) begin
      ph -= longint'(1) << 31;
      flip = 1'b1;
    end else if (ph < -(longint'(1) << 30)) begin
      ph += longint'(1) << 31;
      flip = 1'b1;
    end
    x = 64'h26DD3B6A;
    y = 0;
    z = ph;
    n = (STAGES > 32) ? 32 : STAGES;
    for (int i = 0; i < n; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (z >= 0) begin
        x -= dx; y += dy; z -= arctan_step(i);
      end else begin
        x += dx; y -= dy; z += arctan_step(i);
      end
    end
    c = round_q(x, 14);
    s = round_q(y, 14);
    if (flip) begin
      c = -c;
      s = -s;
    end
  endtask

  function automatic longint mul_q16(longint a, longint b, bit neg);
    longint p;
    p = a * b;
    if (neg) p = -p;
    return round_q(p, 16);
  endfunction

  // Works out the four rows for one link and queues them in order.
  task automatic predict_link(input logic signed [15:0] al, input logic signed [31:0] a,
                              input logic signed [31:0] d, input logic signed [15:0] th);
    longint ca, sa, ct, st;
    matrix_row_t r;
    trig_of(al, ca, sa);
    trig_of(th, ct, st);
    r.row = 2'd0; r.last = 1'b0;
    r.c0 = clamp(ct); r.c1 = clamp(mul_q16(st, ca, 1'b1));
    r.c2 = clamp(mul_q16(st, sa, 1'b0)); r.c3 = clamp(mul_q16(a, ct, 1'b0));
    rows_due.push_back(r);
    r.row = 2'd1;
    r.c0 = clamp(st); r.c1 = clamp(mul_q16(ct, ca, 1'b0));
    r.c2 = clamp(mul_q16(ct, sa, 1'b1)); r.c3 = clamp(mul_q16(a, st, 1'b0));
    rows_due.push_back(r);
    r.row = 2'd2;
    r.c0 = '0; r.c1 = clamp(sa); r.c2 = clamp(ca); r.c3 = clamp(d);
    rows_due.push_back(r);
    r.row = 2'd3; r.last = 1'b1;
    r.c0 = '0; r.c1 = '0; r.c2 = '0; r.c3 = clamp(64'sd65536);
    rows_due.push_back(r);
  endtask

  // Sends one link item; start stays high across back-to-back items and is
  // dropped only by an idle cycle or by stop_sending.
  task automatic send_link(input logic signed [15:0] al, input logic signed [31:0] a,
                           input logic signed [31:0] d, input logic signed [15:0] th);
    while (!quiet_stretch && $urandom_range(99) < 27) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start <= 1'b1;
    twist_angle <= al; link_length <= a; link_offset <= d; joint_angle <= th;
    @(posedge clk);
    while (busy) @(posedge clk);
    predict_link(al, a, d, th);
  endtask

  task automatic stop_sending();
    start <= 1'b0;
  endtask

  // Every row item is compared with the oldest expected row.
  always @(posedge clk) begin
    if (!rst && done) begin
      if (rows_due.size() == 0) begin
        $display("%0t: unexpected row item, row %0d", $time, row_index);
        errors++;
      end else begin
        matrix_row_t e;
        e = rows_due.pop_front();
        if (row_index !== e.row) begin
          $display("%0t: row_index expected %0d actual %0d", $time, e.row, row_index);
          errors++;
        end
        if (col_zero !== e.c0) begin
          $display("%0t: col_zero expected %0d actual %0d", $time, e.c0, col_zero);
          errors++;
        end
        if (col_one !== e.c1) begin
          $display("%0t: col_one expected %0d actual %0d", $time, e.c1, col_one);
          errors++;
        end
        if (col_two !== e.c2) begin
          $display("%0t: col_two expected %0d actual %0d", $time, e.c2, col_two);
          errors++;
        end
        if (col_three !== e.c3) begin
          $display("%0t: col_three expected %0d actual %0d", $time, e.c3, col_three);
          errors++;
        end
        if (last_row !== e.last) begin
          $display("%0t: last_row expected %0d actual %0d", $time, e.last, last_row);
          errors++;
        end
      end
    end
  end

  function automatic logic signed [15:0] any_angle();
    // Mostly legal angles, sometimes the full 16-bit range.
    if ($urandom_range(9) < 2) return 16'($urandom());
    return 16'($urandom_range(46080) - 23040);
  endfunction

  // Extremes of every field, the quadrant boundaries and angles past 180 degrees.
  task automatic test_directed();
    send_link(16'sd0, 32'sd0, 32'sd0, 16'sd0);
    send_link(16'sd23040, 32'sh7FFFFFFF, 32'sh80000000, -16'sd23040);
    send_link(-16'sd23040, 32'sh80000000, 32'sh7FFFFFFF, 16'sd23040);
    send_link(16'sd11520, 32'sh00010000, 32'sh00010000, 16'sd11520);
    send_link(-16'sd11520, -32'sh00010000, 32'sd0, -16'sd11520);
    send_link(16'sd11521, 32'sh7FFFFFFF, 32'sd0, -16'sd11521);
    send_link(16'sd5760, 32'sh7FFFFFFF, 32'sh12345678, 16'sd5760);
    send_link(-16'sd5760, 32'sh80000000, 32'sd0, 16'sd17280);
    send_link(16'sh7FFF, 32'h55555555, 32'hAAAAAAAA, 16'sh8000);
    send_link(16'sh8000, 32'hAAAAAAAA, 32'h55555555, 16'sh7FFF);
    send_link(16'shFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF, 16'sh0001);
    send_link(16'sd3840, 32'sh00028000, -32'sh00008000, 16'sd7680);
  endtask

  // Holds the sender off until every expected row has come out.
  task automatic test_drain_pause();
    stop_sending();
    while (rows_due.size() != 0) @(posedge clk);
    send_link(16'sd1000, 32'sh00100000, 32'sh00200000, -16'sd2000);
  endtask

  task automatic test_random(input int n);
    for (int i = 0; i < n; i++) begin
      quiet_stretch = (i >= 100 && i < 160);
      send_link(any_angle(), $urandom(), $urandom(), any_angle());
    end
    quiet_stretch = 1'b0;
  endtask

  initial begin
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_drain_pause();
    test_random(290);
    stop_sending();
    while (rows_due.size() != 0) @(posedge clk);
    repeat (STAGES + 12) @(posedge clk);
    if (errors == 0 && rows_due.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("== FAIL ==");
    $finish;
  end
endmodule
